// ===== hw/rtl/tprs_pkg.sv =====
// Shared constants and command/status types for the timer prescaler reload search.
package tprs_pkg;

   // Largest divider tried and largest reload count accepted.
   localparam int MAX_DIVIDER  = 65536;
   localparam int RELOAD_LIMIT = 65536;

   // Field and datapath widths.
   localparam int N_W    = 32;
   localparam int OUT_W  = 16;
   localparam int DIV_W  = $clog2(MAX_DIVIDER + 1);
   localparam int REL_W  = $clog2(RELOAD_LIMIT + 1);
   localparam int STEP_W = $clog2(N_W);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // Capture the period and start the first candidate.
      logic step;   // One restoring division step.
      logic mul;    // Register the candidate product.
      logic eval;   // Update the best pair and, unless the search is done, move to the next divider.
      logic latch;  // Load the result registers.
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;    // The best product after this candidate equals the period.
      logic last;   // The current divider is the largest one.
   } dp_status_type;

endpackage

// ===== hw/rtl/tprs_datapath.sv =====
// Datapath: iterative divider, candidate multiplier and best-pair registers.
module tprs_datapath (
   input  logic                         clock,
   input  tprs_pkg::ctrl_cmd_type       cmd,
   output tprs_pkg::dp_status_type      status,
   input  logic [tprs_pkg::N_W-1:0]     period_count,
   output logic [tprs_pkg::OUT_W-1:0]   prescaler_minus_one,
   output logic [tprs_pkg::OUT_W-1:0]   reload_minus_one,
   output logic                         no_fit
);
   import tprs_pkg::*;

   logic [N_W-1:0]   n_ff;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [N_W-1:0]   quot_ff, quot_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0]   prod_ff;
   logic [N_W-1:0]   best_ff, best_in;
   logic [DIV_W-1:0] best_div_ff, best_div_in;
   logic [REL_W-1:0] best_rel_ff, best_rel_in;
   logic [OUT_W-1:0] presc_ff, reload_ff;
   logic             no_fit_ff;

   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   rem_diff;
   logic             rel_ok;
   logic             better;
   logic             done_now;
   logic [DIV_W-1:0] div_m1;
   logic [REL_W-1:0] rel_m1;
   logic [DIV_W+REL_W-1:0] prod_full;

   // One restoring division step: shift in the next dividend bit and try to subtract.
   assign rem_sh   = {rem_ff, quot_ff[N_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   // Candidate qualification and early stop.
   assign rel_ok   = (quot_ff <= N_W'(RELOAD_LIMIT));
   assign better   = rel_ok && (prod_ff > best_ff);
   assign best_in  = better ? prod_ff : best_ff;
   assign best_div_in = better ? div_ff : best_div_ff;
   assign best_rel_in = better ? quot_ff[REL_W-1:0] : best_rel_ff;
   assign status.hit  = (best_in == n_ff);
   assign status.last = (div_ff == DIV_W'(MAX_DIVIDER));
   assign done_now    = status.hit || status.last;

   // Full-width candidate product; it fits the period width whenever the reload qualifies.
   assign prod_full = div_ff * quot_ff[REL_W-1:0];

   // Next divider and division operands.
   always_comb begin
      div_in  = div_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         div_in  = DIV_W'(1);
         quot_in = period_count;
         rem_in  = '0;
      end else if (cmd.step) begin
         if (rem_sh >= {1'b0, div_ff}) begin
            rem_in  = rem_diff[DIV_W-1:0];
            quot_in = {quot_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[DIV_W-1:0];
            quot_in = {quot_ff[N_W-2:0], 1'b0};
         end
      end else if (cmd.eval && !done_now) begin
         div_in  = div_ff + DIV_W'(1);
         quot_in = n_ff;
         rem_in  = '0;
      end
   end

   // Result fields, minus one and truncated to the port width.
   assign div_m1 = best_div_ff - DIV_W'(1);
   assign rel_m1 = best_rel_ff - REL_W'(1);

   // Payload registers.
   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.load) begin
         n_ff        <= period_count;
         best_ff     <= '0;
         best_div_ff <= '0;
         best_rel_ff <= '0;
      end else if (cmd.eval) begin
         best_ff     <= best_in;
         best_div_ff <= best_div_in;
         best_rel_ff <= best_rel_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[N_W-1:0];
      end
      if (cmd.latch) begin
         no_fit_ff <= (best_ff == '0);
         presc_ff  <= (best_ff == '0) ? '0 : div_m1[OUT_W-1:0];
         reload_ff <= (best_ff == '0) ? '0 : rel_m1[OUT_W-1:0];
      end
   end

   assign prescaler_minus_one = presc_ff;
   assign reload_minus_one    = reload_ff;
   assign no_fit              = no_fit_ff;

endmodule

// ===== hw/rtl/tprs_ctrl.sv =====
// Controller: sequences the division, product and compare for each divider tried.
module tprs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output logic                     rsp_strobe,
   output tprs_pkg::ctrl_cmd_type   cmd,
   input  tprs_pkg::dp_status_type  status
);
   import tprs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MUL,
      S_EVAL,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              strobe_ff, strobe_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      step_in   = '0;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(N_W - 1)) begin
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (status.hit || status.last) ? S_DONE : S_DIV;
         end
         S_DONE: begin
            cmd.latch = 1'b1;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

   // The strobe lasts exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for more than one cycle");

   // An accepted transaction makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start the search");

   // The step counter only runs while dividing.
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (step_ff == '0))
      else $error("division step counter active outside division");

   // A strobe follows only the result-latch state.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff) == S_DONE))
      else $error("result strobe without a finished search");

endmodule

// ===== hw/rtl/timer_prescaler_reload_search.sv =====
// Top level: divider/reload pair search for a wanted timer period.
// Search: for each divider tried, 32 division steps, then the product, then the compare;
// it stops at an exact fit or after the largest divider. The shared one-bit-per-cycle
// divider dominates the run time. One transaction at a time: busy drops in the result
// strobe cycle, which lasts one cycle and cannot be stalled, so a new transaction may be taken then.
// Synchronous active-high reset returns the controller to idle; no result is pending.
module timer_prescaler_reload_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [tprs_pkg::N_W-1:0]   req_period_count,
   output logic                       rsp_strobe,
   output logic [tprs_pkg::OUT_W-1:0] rsp_prescaler_minus_one,
   output logic [tprs_pkg::OUT_W-1:0] rsp_reload_minus_one,
   output logic                       rsp_no_fit
);
   import tprs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer.
   tprs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic and result registers.
   tprs_datapath u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .status              (status),
      .period_count        (req_period_count),
      .prescaler_minus_one (rsp_prescaler_minus_one),
      .reload_minus_one    (rsp_reload_minus_one),
      .no_fit              (rsp_no_fit)
   );

endmodule

// ===== test/tb_timer_prescaler_reload_search.sv =====
// Self-checking testbench for the timer prescaler and reload search block.
module tb_timer_prescaler_reload_search;
   import tprs_pkg::*;

   localparam int          CLOCK_HALF    = 5;
   localparam int          RESET_CYCLES  = 3;
   localparam int          RANDOM_ITEMS  = 100;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          DIRECTED_ROWS = 16;
   // The limit allows for one full search of 65536 dividers; the rest of the run is small.
   localparam longint      CYCLE_LIMIT   = 12_000_000;

   // One divider pair as the block reports it, tagged with its period.
   typedef struct packed {
      logic [N_W-1:0]   period;
      logic [OUT_W-1:0] prescaler;
      logic [OUT_W-1:0] reload;
      logic             no_fit;
   } divider_pair_type;

   // A directed row: the pair is only used when known is set.
   typedef struct packed {
      logic             known;
      divider_pair_type pair;
   } period_row_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic [N_W-1:0]       req_period_count = '0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [OUT_W-1:0]     rsp_prescaler_minus_one;
   logic [OUT_W-1:0]     rsp_reload_minus_one;
   logic                 rsp_no_fit;

   divider_pair_type     pending_pairs[$];
   int                   mismatch_count = 0;
   longint               cycle_count    = 0;

   timer_prescaler_reload_search dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_period_count        (req_period_count),
      .rsp_strobe              (rsp_strobe),
      .rsp_prescaler_minus_one (rsp_prescaler_minus_one),
      .rsp_reload_minus_one    (rsp_reload_minus_one),
      .rsp_no_fit              (rsp_no_fit)
   );

   // Free-running clock.
   always #CLOCK_HALF clock = ~clock;

   // Hold reset at the start of the run only.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: a hung search or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timer_prescaler_reload_search test failed");
         $finish;
      end
   end

   // Count a mismatch and report only the first few in detail.
   task automatic note_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, text);
      end
   endtask

   // Try every divider in order and keep the first one with the largest product that does
   // not exceed the period and whose reload is within the limit; an exact fit ends the search.
   function automatic divider_pair_type compute_divider_pair(input logic [N_W-1:0] period);
      divider_pair_type pair;
      longint unsigned  wanted;
      longint unsigned  quotient;
      longint unsigned  product;
      longint unsigned  top_product;
      longint unsigned  best_divider;
      longint unsigned  best_reload;
      wanted       = period;
      top_product  = 0;
      best_divider = 0;
      best_reload  = 0;
      for (longint unsigned divider = 1; divider <= MAX_DIVIDER; divider++) begin
         quotient = wanted / divider;
         if (quotient <= RELOAD_LIMIT) begin
            product = divider * quotient;
            if (product > top_product) begin
               top_product  = product;
               best_divider = divider;
               best_reload  = quotient;
            end
            if (top_product == wanted) break;
         end
      end
      pair.period = period;
      // A zero period leaves every product at zero: no divider pair fits.
      if (top_product == 0) begin
         pair.prescaler = '0;
         pair.reload    = '0;
         pair.no_fit    = 1'b1;
      end else begin
         pair.prescaler = OUT_W'(best_divider - 1);
         pair.reload    = OUT_W'(best_reload - 1);
         pair.no_fit    = 1'b0;
      end
      return pair;
   endfunction

   // Compare each result against the oldest pending pair.
   always @(posedge clock) begin : check_results
      divider_pair_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pairs.size() == 0) begin
            note_mismatch($sformatf("unexpected result prescaler=%0d reload=%0d no_fit=%0b",
                                    rsp_prescaler_minus_one, rsp_reload_minus_one,
                                    rsp_no_fit));
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_prescaler_minus_one !== want.prescaler ||
                rsp_reload_minus_one !== want.reload ||
                rsp_no_fit !== want.no_fit) begin
               note_mismatch($sformatf({"period=%0d expected prescaler=%0d reload=%0d ",
                                        "no_fit=%0b, got prescaler=%0d reload=%0d no_fit=%0b"},
                                       want.period, want.prescaler, want.reload, want.no_fit,
                                       rsp_prescaler_minus_one, rsp_reload_minus_one,
                                       rsp_no_fit));
            end
         end
      end
   end

   // Idle time before a request: mostly none, sometimes short, rarely long.
   function automatic int random_gap();
      int roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 40);
      return $urandom_range(41, 3000);
   endfunction

   // Random periods that end the search early: small periods fit with a
   // divider of one, and products of a small divider and a reload count
   // stop at the first exact divisor.
   function automatic logic [N_W-1:0] random_period();
      int              roll = $urandom_range(0, 99);
      longint unsigned divider;
      longint unsigned reload;
      if (roll < 30) return $urandom_range(0, RELOAD_LIMIT);
      divider = (roll < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      reload  = (roll < 95) ? $urandom_range(1, RELOAD_LIMIT)
                            : $urandom_range(RELOAD_LIMIT - 8, RELOAD_LIMIT);
      return N_W'(divider * reload);
   endfunction

   // Issue one period and record what it should produce once it is taken.
   task automatic send_period(input logic [N_W-1:0] period, input logic known,
                              input divider_pair_type typed);
      int               gap;
      divider_pair_type want;
      gap = random_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_period_count <= period;
      @(posedge clock);
      while (busy) @(posedge clock);
      want        = known ? typed : compute_divider_pair(period);
      want.period = period;
      pending_pairs.push_back(want);
   endtask

   // Stop sending until every pending result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_pairs.size() != 0);
   endtask

   // Directed rows first, then random periods, then drain and report.
   initial begin : stimulus
      period_row_type rows [DIRECTED_ROWS];
      int             k;
      rows = '{
         '{1'b1, '{32'd0,          16'd0,     16'd0,     1'b1}},
         '{1'b1, '{32'd1,          16'd0,     16'd0,     1'b0}},
         '{1'b1, '{32'd2,          16'd0,     16'd1,     1'b0}},
         '{1'b0, '{32'd3,          16'd0,     16'd0,     1'b0}},
         '{1'b1, '{32'h0000_5555,  16'd0,     16'h5554,  1'b0}},
         '{1'b1, '{32'h0000_AAAA,  16'd0,     16'hAAA9,  1'b0}},
         '{1'b1, '{32'd65535,      16'd0,     16'd65534, 1'b0}},
         '{1'b1, '{32'd65536,      16'd0,     16'd65535, 1'b0}},
         '{1'b0, '{32'd65538,      16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'd131072,     16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'd131073,     16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'd196608,     16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'd4194304,    16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'h00AA_AA00,  16'd0,     16'd0,     1'b0}},
         '{1'b0, '{32'h0055_5500,  16'd0,     16'd0,     1'b0}},
         // Largest period: only the largest divider fits, with no exact product.
         '{1'b1, '{32'hFFFF_FFFF,  16'd65535, 16'd65534, 1'b0}}
      };
      while (reset) @(posedge clock);

      for (k = 0; k < DIRECTED_ROWS; k++) begin
         send_period(rows[k].pair.period, rows[k].known, rows[k].pair);
      end
      wait_for_results();

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         send_period(random_period(), 1'b0, '0);
         if ($urandom_range(0, 24) == 0) wait_for_results();
      end
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_pairs.size() == 0) begin
         $display("timer_prescaler_reload_search test passed");
      end else begin
         $display("timer_prescaler_reload_search test failed");
      end
      $finish;
   end

endmodule
